// ----- design/mlfc_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfc_pkg
// Types and constants shared by the MAC learning flow controller.
// ----------------------------------------------------------------------------
package mlfc_pkg;

   localparam logic [15:0] PORT_FLOOD  = 16'd65531;
   localparam logic        CMD_ADD     = 1'b0;
   localparam logic        CMD_MODIFY  = 1'b1;
   localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] BUF_NONE    = 32'hFFFF_FFFF;
   localparam logic        CSR_SWITCHES = 1'b0;
   localparam logic        CSR_TIMEOUT  = 1'b1;

   typedef struct packed {
      logic [1:0]  switch_id;
      logic [15:0] in_port;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] ip_src;
      logic [31:0] ip_dst;
      logic [15:0] l4_src;
      logic [15:0] l4_dst;
      logic [31:0] pkt_buffer;
   } req_type;

   typedef struct packed {
      logic        command;
      logic [15:0] flow_in_port;
      logic [47:0] flow_src_mac;
      logic [47:0] flow_dst_mac;
      logic [31:0] flow_ip_src;
      logic [31:0] flow_ip_dst;
      logic [15:0] flow_l4_src;
      logic [15:0] flow_l4_dst;
      logic [15:0] action_port;
      logic [31:0] flow_buffer;
      logic        learn_dropped;
      logic        last;
   } rsp_type;

   // search token passed cell to cell
   typedef struct packed {
      logic        active;
      logic [47:0] dst_mac;
      logic [47:0] src_mac;
      logic        dst_hit;
      logic [15:0] dst_port;
      logic        src_hit;
   } probe_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ADD,
      ST_MOD
   } state_type;

endpackage

// ----- design/mlfc_cell.sv -----
// ----------------------------------------------------------------------------
// mlfc_cell
// One table entry: holds a learned MAC and port, compares a passing probe.
// ----------------------------------------------------------------------------
module mlfc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                write_en,
   input  logic [47:0]         write_mac,
   input  logic [15:0]         write_port,
   input  mlfc_pkg::probe_type probe_in,
   output mlfc_pkg::probe_type probe_out
);
   import mlfc_pkg::*;

   logic        valid_ff;
   logic [47:0] mac_ff;
   logic [15:0] port_ff;
   probe_type   probe_ff, probe_in_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (write_en) begin
         valid_ff <= 1'b1;
      end
      if (write_en) begin
         mac_ff  <= write_mac;
         port_ff <= write_port;
      end
   end

   always_comb begin
      probe_in_c = probe_in;
      if (valid_ff && !probe_in.dst_hit && mac_ff == probe_in.dst_mac) begin
         probe_in_c.dst_hit  = 1'b1;
         probe_in_c.dst_port = port_ff;
      end
      if (valid_ff && mac_ff == probe_in.src_mac) begin
         probe_in_c.src_hit = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.active <= 1'b0;
      end else begin
         probe_ff.active <= probe_in.active;
      end
      probe_ff.dst_mac  <= probe_in_c.dst_mac;
      probe_ff.src_mac  <= probe_in_c.src_mac;
      probe_ff.dst_hit  <= probe_in_c.dst_hit;
      probe_ff.dst_port <= probe_in_c.dst_port;
      probe_ff.src_hit  <= probe_in_c.src_hit;
   end

   assign probe_out = probe_ff;

endmodule

// ----- design/mlfc_chain.sv -----
// ----------------------------------------------------------------------------
// mlfc_chain
// Per-switch row of cells; a probe walks one cell per cycle.
// ----------------------------------------------------------------------------
module mlfc_chain #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                write_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] write_slot,
   input  logic [47:0]         write_mac,
   input  logic [15:0]         write_port,
   input  mlfc_pkg::probe_type probe_in,
   output mlfc_pkg::probe_type probe_out
);
   import mlfc_pkg::*;

   localparam int SLOT_W = $clog2(TABLE_ENTRIES);

   probe_type link [TABLE_ENTRIES+1];

   assign link[0] = probe_in;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      mlfc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .write_en   (write_en && write_slot == SLOT_W'(g)),
         .write_mac  (write_mac),
         .write_port (write_port),
         .probe_in   (link[g]),
         .probe_out  (link[g+1])
      );
   end

   assign probe_out = link[TABLE_ENTRIES];

endmodule

// ----- design/mac_learning_flow_controller.sv -----
// ----------------------------------------------------------------------------
// mac_learning_flow_controller
// Packet-in handler with per-switch MAC learning; emits add and modify flows.
// ----------------------------------------------------------------------------
// Each switch owns a chain of TABLE_ENTRIES cells. An event sends one probe
// down its switch's chain, one cell per cycle, checking destination and
// source MAC together; one event is in work at a time. Events from switches
// not registered are accepted and dropped with no result. flow_timeout is
// stored but does not appear in any result.
module mac_learning_flow_controller #(
   parameter int NUM_SWITCHES  = 4,
   parameter int TABLE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlfc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mlfc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [15:0]       csr_data
);
   import mlfc_pkg::*;

   localparam int SW_W   = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
   localparam int SLOT_W = $clog2(TABLE_ENTRIES);
   localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

   state_type   state_ff, state_in;
   logic [3:0]  switches_ff;
   logic [15:0] timeout_ff;
   req_type     item_ff;
   logic [SW_W-1:0] sw_ff;
   logic [15:0] outp_ff;
   logic        srchit_ff;
   logic [FILL_W-1:0] fill_ff [NUM_SWITCHES];
   logic        accept, registered, chain_done, full;
   probe_type   probe_in [NUM_SWITCHES];
   probe_type   probe_out [NUM_SWITCHES];
   probe_type   done_probe;
   logic        write_en;

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign registered = ({30'd0, req_data.switch_id} < NUM_SWITCHES) &&
                       switches_ff[req_data.switch_id];

   always_ff @(posedge clock) begin
      if (reset) begin
         switches_ff <= 4'd0;
         timeout_ff  <= 16'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SWITCHES: switches_ff <= csr_data[3:0];
            CSR_TIMEOUT:  timeout_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      done_probe = probe_out[0];
      for (int s = 0; s < NUM_SWITCHES; s++) begin
         if (sw_ff == s[SW_W-1:0]) done_probe = probe_out[s];
      end
   end

   assign chain_done = done_probe.active;
   assign full       = fill_ff[sw_ff] >= FILL_W'(TABLE_ENTRIES);
   assign write_en   = state_ff == ST_ADD && !rsp_stall && !srchit_ff && !full;

   for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_sw
      always_comb begin
         probe_in[s]          = '0;
         probe_in[s].active   = accept && registered &&
                                req_data.switch_id[SW_W-1:0] == SW_W'(s);
         probe_in[s].dst_mac  = req_data.dst_mac;
         probe_in[s].src_mac  = req_data.src_mac;
         probe_in[s].dst_hit  = req_data.dst_mac == MAC_BCAST;
         probe_in[s].dst_port = PORT_FLOOD;
      end
      mlfc_chain #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_chain (
         .clock      (clock),
         .reset      (reset),
         .write_en   (write_en && sw_ff == SW_W'(s)),
         .write_slot (fill_ff[s][SLOT_W-1:0]),
         .write_mac  (item_ff.src_mac),
         .write_port (item_ff.in_port),
         .probe_in   (probe_in[s]),
         .probe_out  (probe_out[s])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            fill_ff[s] <= '0;
         end else if (write_en && sw_ff == SW_W'(s)) begin
            fill_ff[s] <= fill_ff[s] + 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && registered) state_in = ST_SCAN;
         ST_SCAN: if (chain_done) state_in = ST_ADD;
         ST_ADD:  if (!rsp_stall) state_in = (srchit_ff || full) ? ST_IDLE : ST_MOD;
         ST_MOD:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         item_ff <= req_data;
         sw_ff   <= req_data.switch_id[SW_W-1:0];
      end
      if (state_ff == ST_SCAN && chain_done) begin
         outp_ff   <= done_probe.dst_port;
         srchit_ff <= done_probe.src_hit;
      end
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_ADD || state_ff == ST_MOD;
      rsp_data  = '0;
      case (state_ff)
         ST_MOD: begin
            rsp_data.command       = CMD_MODIFY;
            rsp_data.flow_in_port  = outp_ff;
            rsp_data.flow_src_mac  = item_ff.dst_mac;
            rsp_data.flow_dst_mac  = item_ff.src_mac;
            rsp_data.flow_ip_src   = item_ff.ip_dst;
            rsp_data.flow_ip_dst   = item_ff.ip_src;
            rsp_data.flow_l4_src   = item_ff.l4_dst;
            rsp_data.flow_l4_dst   = item_ff.l4_src;
            rsp_data.action_port   = item_ff.in_port;
            rsp_data.flow_buffer   = BUF_NONE;
            rsp_data.last          = 1'b1;
         end
         default: begin
            rsp_data.command       = CMD_ADD;
            rsp_data.flow_in_port  = item_ff.in_port;
            rsp_data.flow_src_mac  = item_ff.src_mac;
            rsp_data.flow_dst_mac  = item_ff.dst_mac;
            rsp_data.flow_ip_src   = item_ff.ip_src;
            rsp_data.flow_ip_dst   = item_ff.ip_dst;
            rsp_data.flow_l4_src   = item_ff.l4_src;
            rsp_data.flow_l4_dst   = item_ff.l4_dst;
            rsp_data.action_port   = outp_ff;
            rsp_data.flow_buffer   = item_ff.pkt_buffer;
            rsp_data.learn_dropped = !srchit_ff && full;
            rsp_data.last          = srchit_ff || full;
         end
      endcase
   end

endmodule

// ----- test/mac_learning_flow_controller_test.sv -----
// ----------------------------------------------------------------------------
// mac_learning_flow_controller_test
// Drives packet-in events with random gaps and stalls, predicts the add and
// modify flows from a per-switch learning table, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mac_learning_flow_controller_test;
   import mlfc_pkg::*;

   localparam int N_SW     = 4;
   localparam int N_ENTRY  = 64;
   localparam int IDLE_MAX = 20000;
   localparam int REQ_W    = $bits(req_type);

   class flow_scoreboard;
      logic [3:0]  sw_enable;
      logic [47:0] mac_tab [N_SW][N_ENTRY];
      logic [15:0] port_tab[N_SW][N_ENTRY];
      int          fill[N_SW];
      rsp_type     pending[$];
      int          errors;
      int          n_add, n_mod, n_drop, n_hit, n_ignored;

      function void clear();
         sw_enable = '0;
         errors = 0;
         foreach (fill[i]) fill[i] = 0;
      endfunction

      function int find(int sw, logic [47:0] mac);
         for (int i = 0; i < fill[sw]; i++)
            if (mac_tab[sw][i] == mac) return i;
         return -1;
      endfunction

      function void note_event(req_type r);
         rsp_type a, m;
         int      sw, h;
         logic [15:0] outp;
         sw = r.switch_id;
         outp = PORT_FLOOD;
         if (!sw_enable[sw]) begin
            n_ignored++;
            return;
         end
         if (r.dst_mac != MAC_BCAST) begin
            h = find(sw, r.dst_mac);
            if (h >= 0) begin
               outp = port_tab[sw][h];
               n_hit++;
            end
         end
         a = '{CMD_ADD, r.in_port, r.src_mac, r.dst_mac, r.ip_src, r.ip_dst,
               r.l4_src, r.l4_dst, outp, r.pkt_buffer, 1'b0, 1'b1};
         n_add++;
         if (find(sw, r.src_mac) >= 0) begin
            pending.push_back(a);
         end else if (fill[sw] >= N_ENTRY) begin
            a.learn_dropped = 1'b1;
            n_drop++;
            pending.push_back(a);
         end else begin
            a.last = 1'b0;
            pending.push_back(a);
            mac_tab[sw][fill[sw]] = r.src_mac;
            port_tab[sw][fill[sw]] = r.in_port;
            fill[sw]++;
            m = '{CMD_MODIFY, outp, r.dst_mac, r.src_mac, r.ip_dst, r.ip_src,
                  r.l4_dst, r.l4_src, r.in_port, BUF_NONE, 1'b0, 1'b1};
            pending.push_back(m);
            n_mod++;
         end
      endfunction

      function void check_flow(rsp_type g);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result %h", g);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.command !== e.command) begin
            $error("command exp %h got %h", e.command, g.command); errors++; end
         if (g.flow_in_port !== e.flow_in_port) begin
            $error("flow_in_port exp %h got %h", e.flow_in_port, g.flow_in_port);
            errors++; end
         if (g.flow_src_mac !== e.flow_src_mac) begin
            $error("flow_src_mac exp %h got %h", e.flow_src_mac, g.flow_src_mac);
            errors++; end
         if (g.flow_dst_mac !== e.flow_dst_mac) begin
            $error("flow_dst_mac exp %h got %h", e.flow_dst_mac, g.flow_dst_mac);
            errors++; end
         if (g.flow_ip_src !== e.flow_ip_src) begin
            $error("flow_ip_src exp %h got %h", e.flow_ip_src, g.flow_ip_src);
            errors++; end
         if (g.flow_ip_dst !== e.flow_ip_dst) begin
            $error("flow_ip_dst exp %h got %h", e.flow_ip_dst, g.flow_ip_dst);
            errors++; end
         if (g.flow_l4_src !== e.flow_l4_src) begin
            $error("flow_l4_src exp %h got %h", e.flow_l4_src, g.flow_l4_src);
            errors++; end
         if (g.flow_l4_dst !== e.flow_l4_dst) begin
            $error("flow_l4_dst exp %h got %h", e.flow_l4_dst, g.flow_l4_dst);
            errors++; end
         if (g.action_port !== e.action_port) begin
            $error("action_port exp %h got %h", e.action_port, g.action_port);
            errors++; end
         if (g.flow_buffer !== e.flow_buffer) begin
            $error("flow_buffer exp %h got %h", e.flow_buffer, g.flow_buffer);
            errors++; end
         if (g.learn_dropped !== e.learn_dropped) begin
            $error("learn_dropped exp %h got %h", e.learn_dropped, g.learn_dropped);
            errors++; end
         if (g.last !== e.last) begin
            $error("last exp %h got %h", e.last, g.last); errors++; end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_index = CSR_SWITCHES;
   logic [15:0] csr_data = '0;

   flow_scoreboard flows = new();
   int  idle_cycles = 0;
   bit  hold_off = 0;
   bit  hold_done = 0;
   logic [47:0] mac_pool[16];

   mac_learning_flow_controller #(.NUM_SWITCHES(N_SW), .TABLE_ENTRIES(N_ENTRY)) i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .csr_valid, .csr_ready, .csr_index, .csr_data);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // watchdog and result sampling
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) flows.check_flow(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_MAX) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // receiver: random stalls, one long hold-off when asked
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (600) @(negedge clock);
            hold_done = 1;
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(negedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   task automatic send_event(req_type r);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      flows.note_event(r);
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SWITCHES) flows.sw_enable = val[3:0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      int t;
      t = 0;
      req_valid <= 1'b0;
      while (flows.pending.size() != 0 && t < 200000) begin
         @(negedge clock);
         t++;
      end
      repeat (3 * N_ENTRY + 20) @(negedge clock);
   endtask

   function automatic req_type rand_event();
      req_type r;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom});
      r.switch_id = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 8) begin
         r.src_mac = mac_pool[$urandom_range(0, 15)];
         r.dst_mac = mac_pool[$urandom_range(0, 15)];
         if ($urandom_range(0, 9) == 0) r.dst_mac = MAC_BCAST;
         if ($urandom_range(0, 19) == 0) r.dst_mac = r.src_mac;
      end
      return r;
   endfunction

   initial begin
      req_type r;
      flows.clear();
      foreach (mac_pool[i]) mac_pool[i] = 48'({$urandom, $urandom});
      mac_pool[0] = '0;
      mac_pool[1] = MAC_BCAST - 1;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // nothing registered: events dropped
      r = '1; r.dst_mac = 48'h1; send_event(r);
      drain();
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      write_csr(CSR_SWITCHES, 16'h000F);
      // directed: extremes, broadcast, learned hit, src == dst
      r = '0; send_event(r);
      r = '1; send_event(r);
      r = '0; r.dst_mac = '0; r.src_mac = 48'h5; r.in_port = 16'h1234; send_event(r);
      r = '1; r.src_mac = 48'h7; r.dst_mac = 48'h7; r.switch_id = 2'd1; send_event(r);
      r = '0; r.switch_id = 2'd1; r.src_mac = 48'h8; r.dst_mac = 48'h7; send_event(r);
      r = '0; r.switch_id = 2'd3; r.src_mac = MAC_BCAST; r.dst_mac = MAC_BCAST;
      send_event(r);
      drain();
      write_csr(CSR_SWITCHES, 16'h0005);
      write_csr(CSR_TIMEOUT, 16'h0000);
      for (int i = 0; i < 8; i++) begin
         r = rand_event(); r.switch_id = i[1:0]; send_event(r);
      end
      drain();

      // fill switch 2 past capacity to hit the full-table case
      for (int i = 0; i < N_ENTRY + 6; i++) begin
         r = rand_event();
         r.switch_id = 2'd2; r.src_mac = {16'hA5A5, i[31:0]};
         send_event(r);
      end
      drain();

      write_csr(CSR_SWITCHES, 16'h000F);
      write_csr(CSR_TIMEOUT, 16'($urandom));
      // long receiver hold-off while events keep coming
      hold_off = 1;
      for (int i = 0; i < 40; i++) send_event(rand_event());
      for (int i = 0; i < 350; i++) send_event(rand_event());
      drain();
      write_csr(CSR_SWITCHES, 16'h000A);
      write_csr(CSR_TIMEOUT, 16'h8001);
      for (int i = 0; i < 200; i++) send_event(rand_event());
      drain();
      write_csr(CSR_SWITCHES, 16'h000F);
      for (int i = 0; i < 175; i++) send_event(rand_event());
      drain();

      $display("covered %0d add and %0d modify flows, %0d learned hits, %0d drops",
               flows.n_add, flows.n_mod, flows.n_hit, flows.n_drop);
      $display("%0d events from unregistered switches ignored", flows.n_ignored);
      if (flows.errors == 0 && flows.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
